@@ rtl/core/pthe_pkg.sv @@
// ----------------------------------------------------------------------------
// pthe_pkg: shared types and constants of the packet trace header extractor
// Record layout, output word layout, status codes and byte positions.
// ----------------------------------------------------------------------------
`default_nettype none

package pthe_pkg;

  // Stream widths.
  localparam int unsigned IN_W  = 8;
  localparam int unsigned OUT_W = 264;
  localparam int unsigned POS_W = 17;
  localparam int unsigned CAP_W = 16;

  // Record and frame size limits.
  localparam int unsigned HDR_LEN = 12;
  localparam int unsigned ETH_MIN = 14;
  localparam int unsigned IP_MIN  = 34;

  localparam logic [15:0] IPV4_TYPE = 16'h0800;
  localparam logic [3:0]  IHL_MASK  = 4'hF;

  // Byte positions within a record (trace header, then the frame).
  localparam int unsigned POS_SEC_FIRST  = 0;
  localparam int unsigned POS_SEC_LAST   = 3;
  localparam int unsigned POS_USEC_FIRST = 4;
  localparam int unsigned POS_USEC_LAST  = 7;
  localparam int unsigned POS_CAP_FIRST  = 8;
  localparam int unsigned POS_CAP_LAST   = 9;
  localparam int unsigned POS_DMAC_FIRST = 12;
  localparam int unsigned POS_DMAC_LAST  = 17;
  localparam int unsigned POS_SMAC_FIRST = 18;
  localparam int unsigned POS_SMAC_LAST  = 23;
  localparam int unsigned POS_TYPE_FIRST = 24;
  localparam int unsigned POS_TYPE_LAST  = 25;
  localparam int unsigned POS_IHL        = 26;
  localparam int unsigned POS_TTL        = 34;
  localparam int unsigned POS_PROTO      = 35;
  localparam int unsigned POS_SIP_FIRST  = 38;
  localparam int unsigned POS_SIP_LAST   = 41;
  localparam int unsigned POS_DIP_FIRST  = 42;
  localparam int unsigned POS_DIP_LAST   = 45;

  // Record queue sizing.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ETH_TRUNC = 2'd1,
    ST_IP_TRUNC  = 2'd2,
    ST_NON_IPV4  = 2'd3
  } status_t;

  // Raw fields gathered from one record.
  typedef struct packed {
    logic [31:0]      seconds;
    logic [31:0]      micros;
    logic [47:0]      dest_mac;
    logic [47:0]      source_mac;
    logic [15:0]      ether_type;
    logic [3:0]       ihl;
    logic [7:0]       ttl;
    logic [7:0]       protocol;
    logic [31:0]      source_ip;
    logic [31:0]      dest_ip;
    logic [CAP_W-1:0] cap_len;
  } pthe_rec_t;

  // A record moving between front end, queue and back end.
  typedef struct packed {
    logic      valid;
    pthe_rec_t rec;
  } pthe_xfer_t;

  // Result word; the last member lands in the lowest bits of tdata.
  typedef struct packed {
    status_t     status;
    logic [7:0]  time_to_live;
    logic [7:0]  ip_protocol;
    logic [5:0]  header_bytes;
    logic [31:0] dest_ip;
    logic [31:0] source_ip;
    logic [15:0] ether_type;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] stamp_micros;
    logic [31:0] stamp_seconds;
  } pthe_out_t;

endpackage

`default_nettype wire

@@ rtl/core/pthe_front.sv @@
// ----------------------------------------------------------------------------
// pthe_front: byte parser
// Tracks the byte position in a record, gathers header fields and pushes the
// finished record into the queue on the record's last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pthe_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [pthe_pkg::IN_W-1:0] in_tdata,   // [7:0] data_byte
  input  wire logic                      q_full,
  output pthe_pkg::pthe_xfer_t           push
);
  import pthe_pkg::*;

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  pthe_rec_t        rec_r;
  pthe_rec_t        rec_nxt;
  logic             accept;
  logic             last_byte;
  logic [7:0]       b;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;

  // Fold the current byte into the field that its position selects.
  always_comb begin
    rec_nxt = rec_r;
    case (pos_r) inside
      [POS_SEC_FIRST:POS_SEC_LAST]:   rec_nxt.seconds    = {rec_r.seconds[23:0], b};
      [POS_USEC_FIRST:POS_USEC_LAST]: rec_nxt.micros     = {rec_r.micros[23:0], b};
      [POS_CAP_FIRST:POS_CAP_LAST]:   rec_nxt.cap_len    = {rec_r.cap_len[7:0], b};
      [POS_DMAC_FIRST:POS_DMAC_LAST]: rec_nxt.dest_mac   = {rec_r.dest_mac[39:0], b};
      [POS_SMAC_FIRST:POS_SMAC_LAST]: rec_nxt.source_mac = {rec_r.source_mac[39:0], b};
      [POS_TYPE_FIRST:POS_TYPE_LAST]: rec_nxt.ether_type = {rec_r.ether_type[7:0], b};
      POS_IHL:                        rec_nxt.ihl        = b[3:0] & IHL_MASK;
      POS_TTL:                        rec_nxt.ttl        = b;
      POS_PROTO:                      rec_nxt.protocol   = b;
      [POS_SIP_FIRST:POS_SIP_LAST]:   rec_nxt.source_ip  = {rec_r.source_ip[23:0], b};
      [POS_DIP_FIRST:POS_DIP_LAST]:   rec_nxt.dest_ip    = {rec_r.dest_ip[23:0], b};
      default: ;
    endcase
  end

  // The record ends at position capture length plus eleven. Before position
  // ten the capture length is not complete, and no record can end there.
  assign last_byte = (pos_r >= POS_W'(HDR_LEN - 2)) &&
                     (pos_r >= ({1'b0, rec_r.cap_len} + POS_W'(HDR_LEN - 1)));

  assign pos_nxt = pos_r + POS_W'(1);

  // Hand the completed record to the queue.
  assign push.valid = accept && last_byte;
  assign push.rec   = rec_nxt;

  // Position and field registers; everything clears after each record.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      rec_r <= '0;
    end else if (accept) begin
      if (last_byte) begin
        pos_r <= '0;
        rec_r <= '0;
      end else begin
        pos_r <= pos_nxt;
        rec_r <= rec_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pthe_queue.sv @@
// ----------------------------------------------------------------------------
// pthe_queue: record queue
// Two-entry queue that decouples the byte parser from the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pthe_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pthe_pkg::pthe_xfer_t push,
  output logic                      q_full,
  output pthe_pkg::pthe_xfer_t      head,
  input  wire logic                 pop
);
  import pthe_pkg::*;

  pthe_rec_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_CNT_W-1:0] cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign q_full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.rec   = mem_r[rd_ptr_r];

  assign do_push = push.valid && !q_full;
  assign do_pop  = pop && head.valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.rec;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pthe_back.sv @@
// ----------------------------------------------------------------------------
// pthe_back: result stage
// Classifies the queued record, blanks fields without meaning and holds the
// result in the output register until the transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module pthe_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pthe_pkg::pthe_xfer_t       head,
  output logic                            pop,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [pthe_pkg::OUT_W-1:0]      out_tdata
);
  import pthe_pkg::*;

  status_t   status;
  pthe_out_t res_nxt;
  pthe_out_t res_r;
  logic      out_valid_r;
  logic      eth_ok;
  logic      ip_ok;

  // Status precedence: Ethernet truncation, then IP truncation, then type.
  always_comb begin
    if (head.rec.cap_len < CAP_W'(ETH_MIN)) begin
      status = ST_ETH_TRUNC;
    end else if (head.rec.cap_len < CAP_W'(IP_MIN)) begin
      status = ST_IP_TRUNC;
    end else if (head.rec.ether_type != IPV4_TYPE) begin
      status = ST_NON_IPV4;
    end else begin
      status = ST_OK;
    end
  end

  assign eth_ok = (status != ST_ETH_TRUNC);
  assign ip_ok  = (status == ST_OK);

  // Build the result word with meaningless fields forced to zero.
  always_comb begin
    res_nxt.stamp_seconds = head.rec.seconds;
    res_nxt.stamp_micros  = head.rec.micros;
    res_nxt.source_mac    = eth_ok ? head.rec.source_mac : '0;
    res_nxt.dest_mac      = eth_ok ? head.rec.dest_mac : '0;
    res_nxt.ether_type    = eth_ok ? head.rec.ether_type : '0;
    res_nxt.source_ip     = ip_ok ? head.rec.source_ip : '0;
    res_nxt.dest_ip       = ip_ok ? head.rec.dest_ip : '0;
    res_nxt.header_bytes  = ip_ok ? {head.rec.ihl, 2'b00} : '0;
    res_nxt.ip_protocol   = ip_ok ? head.rec.protocol : '0;
    res_nxt.time_to_live  = ip_ok ? head.rec.ttl : '0;
    res_nxt.status        = status;
  end

  // Load the output register whenever it is empty or being drained.
  assign pop = head.valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

endmodule

`default_nettype wire

@@ rtl/core/packet_trace_header_extractor_unit.sv @@
// Result path: the record's last byte is stored in the queue and then loaded
// into the output register, which raises out_tvalid, when that register is free.
// Throughput: one byte per cycle; in_tready falls only while the two-entry
// record queue is full, which a stalled result port causes.
// Reset: synchronous, active low; it clears the parser position and fields,
// the queue and the output valid.
// ----------------------------------------------------------------------------
// packet_trace_header_extractor_unit: top level
// Parses a byte stream of trace records and emits one header summary per
// record.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_trace_header_extractor_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // [7:0] data_byte
  input  wire logic [pthe_pkg::IN_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // [31:0] stamp_seconds, [63:32] stamp_micros, [111:64] source_mac,
  // [159:112] dest_mac, [175:160] ether_type, [207:176] source_ip,
  // [239:208] dest_ip, [245:240] header_bytes, [253:246] ip_protocol,
  // [261:254] time_to_live, [263:262] status
  output logic [pthe_pkg::OUT_W-1:0]      out_tdata
);
  import pthe_pkg::*;

  pthe_xfer_t push;
  pthe_xfer_t head;
  logic       q_full;
  logic       pop;

  // Front end: byte parser.
  pthe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push)
  );

  // Record queue between the two halves.
  pthe_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .q_full (q_full),
    .head   (head),
    .pop    (pop)
  );

  // Back end: classification and output register.
  pthe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/core/pthe_checker.sv @@
// ----------------------------------------------------------------------------
// pthe_checker: port-level checks
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pthe_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_tvalid,
  input wire logic                      in_tready,
  input wire logic [pthe_pkg::IN_W-1:0] in_tdata,
  input wire logic                      out_tvalid,
  input wire logic                      out_tready,
  input wire logic [pthe_pkg::OUT_W-1:0] out_tdata
);
  import pthe_pkg::*;

  logic in_xfer;

  assign in_xfer = in_tvalid && in_tready;

  // A reset cycle leaves no result pending.
  a_reset_clears : assert property (@(posedge clk)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result pending after reset");

  // A stalled result stays offered.
  a_valid_holds : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A fresh result is preceded by an input transfer, with the queue and the output register between them.
  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_xfer, 2))
    else $error("result without a preceding byte transfer");

  // A good IPv4 result carries the IPv4 EtherType; checked only while the input byte is known.
  a_ok_type : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[263:262] == ST_OK) && !$isunknown(in_tdata)
      |-> out_tdata[175:160] == IPV4_TYPE)
    else $error("status ok without IPv4 EtherType");

endmodule

bind packet_trace_header_extractor_unit pthe_checker u_pthe_checker (.*);

`default_nettype wire
